// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the barycentric weight pipeline.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CBC_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define CBC_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/cbc_pkg.sv =====
// ----------------------------------------------------------------------------
// cbc_pkg
// Widths, codes and types shared by the barycentric weight pipeline.
// ----------------------------------------------------------------------------
package cbc_pkg;

  // Field and intermediate widths.
  localparam int COORD_W   = 24;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int MUL_W     = 2 * DIFF_W;
  localparam int DOT_W     = MUL_W + 1;
  localparam int SPLIT_LO  = 25;
  localparam int SPLIT_HI  = DOT_W - SPLIT_LO;
  localparam int PP_W      = 2 * SPLIT_HI;
  localparam int PROD_W    = 102;
  localparam int NUM_W     = PROD_W + 1;
  localparam int MAG_W     = PROD_W;
  localparam int QUO_W     = 33;
  localparam int FRAC_PAD  = 17;
  localparam int PRE_SHIFT = QUO_W - FRAC_PAD;
  localparam int WGT_W     = 32;
  localparam int T_W       = 17;
  localparam int NUM_EDGES = 3;

  // Edge codes, in the order the clamp tests them.
  localparam int EDGE_BC = 0;
  localparam int EDGE_CA = 1;
  localparam int EDGE_AB = 2;

  // Cycles from the edge that accepts an item to the edge that takes its result.
  localparam int PIPE_LATENCY = 43;

  localparam logic [WGT_W-1:0] ONE_Q16 = 32'd65536;
  localparam logic [WGT_W-1:0] WGT_MAX = 32'h7FFF_FFFF;
  localparam logic [WGT_W-1:0] WGT_MIN = 32'h8000_0000;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DOT_W-1:0]   dot_t;

  typedef struct packed {
    coord_t px, py, pz;
    coord_t ax, ay, az;
    coord_t bx, by, bz;
    coord_t cx, cy, cz;
  } item_t;

  typedef struct packed {
    dot_t [NUM_EDGES-1:0] en;
    dot_t [NUM_EDGES-1:0] ed;
  } edges_t;

  typedef struct packed {
    logic   valid;
    dot_t   d00, d01, d11, d20, d21;
    edges_t edges;
  } dots_t;

  typedef struct packed {
    logic             valid;
    logic             degen;
    logic             neg_v, neg_w;
    logic [MAG_W-1:0] mag_v, mag_w, gram;
    edges_t           edges;
  } gram_t;

  typedef struct packed {
    logic                 degen;
    logic                 neg_v, ovf_v;
    logic                 neg_w, ovf_w;
    logic [NUM_EDGES-1:0] e_zero, e_low, e_high;
  } side_t;

endpackage

// ===== hdl/cbc_dots.sv =====
// ----------------------------------------------------------------------------
// cbc_dots
// Edge differences, per-axis products and the dot-product sums (3 stages).
// ----------------------------------------------------------------------------
module cbc_dots (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  cbc_pkg::item_t item,
  output cbc_pkg::dots_t dots
);
  import cbc_pkg::*;

  localparam int NUM_VEC = 7;
  localparam int NUM_DOT = 9;
  // Vectors: e0, e1, e2, P-B, C-B, P-C, A-C.
  // Dots: d00, d01, d11, d20, d21, bc num, bc den, ca num, ca den.
  localparam int PAIR_A [NUM_DOT] = '{0, 0, 1, 2, 2, 3, 4, 5, 6};
  localparam int PAIR_B [NUM_DOT] = '{0, 1, 1, 0, 1, 4, 4, 6, 6};

  logic signed [DIFF_W-1:0] dif_next [NUM_VEC][3];
  logic signed [DIFF_W-1:0] dif      [NUM_VEC][3];
  logic signed [MUL_W-1:0]  prod     [NUM_DOT][3];
  logic signed [DOT_W-1:0]  dsum     [NUM_DOT];
  logic [2:0]               vld;
  logic signed [DIFF_W-1:0] pt [3], va [3], vb [3], vc [3];

  // Sign-extend the coordinates so differences are exact.
  always_comb begin
    pt[0] = {item.px[COORD_W-1], item.px};
    pt[1] = {item.py[COORD_W-1], item.py};
    pt[2] = {item.pz[COORD_W-1], item.pz};
    va[0] = {item.ax[COORD_W-1], item.ax};
    va[1] = {item.ay[COORD_W-1], item.ay};
    va[2] = {item.az[COORD_W-1], item.az};
    vb[0] = {item.bx[COORD_W-1], item.bx};
    vb[1] = {item.by[COORD_W-1], item.by};
    vb[2] = {item.bz[COORD_W-1], item.bz};
    vc[0] = {item.cx[COORD_W-1], item.cx};
    vc[1] = {item.cy[COORD_W-1], item.cy};
    vc[2] = {item.cz[COORD_W-1], item.cz};
    for (int k = 0; k < 3; k++) begin
      dif_next[0][k] = vb[k] - va[k];
      dif_next[1][k] = vc[k] - va[k];
      dif_next[2][k] = pt[k] - va[k];
      dif_next[3][k] = pt[k] - vb[k];
      dif_next[4][k] = vc[k] - vb[k];
      dif_next[5][k] = pt[k] - vc[k];
      dif_next[6][k] = va[k] - vc[k];
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[1:0], in_valid};
    end
  end

  // Difference, product and sum stages.
  always_ff @(posedge clk) begin
    dif <= dif_next;
    for (int d = 0; d < NUM_DOT; d++) begin
      for (int k = 0; k < 3; k++) begin
        prod[d][k] <= dif[PAIR_A[d]][k] * dif[PAIR_B[d]][k];
      end
      dsum[d] <= DOT_W'(prod[d][0]) + DOT_W'(prod[d][1]) + DOT_W'(prod[d][2]);
    end
  end

  always_comb begin
    dots.valid = vld[2];
    dots.d00   = dsum[0];
    dots.d01   = dsum[1];
    dots.d11   = dsum[2];
    dots.d20   = dsum[3];
    dots.d21   = dsum[4];
    dots.edges.en[EDGE_BC] = dsum[5];
    dots.edges.ed[EDGE_BC] = dsum[6];
    dots.edges.en[EDGE_CA] = dsum[7];
    dots.edges.ed[EDGE_CA] = dsum[8];
    dots.edges.en[EDGE_AB] = dsum[3];
    dots.edges.ed[EDGE_AB] = dsum[0];
  end

endmodule

// ===== hdl/cbc_gram.sv =====
// ----------------------------------------------------------------------------
// cbc_gram
// Gram determinant and weight numerators from split products (4 stages).
// ----------------------------------------------------------------------------
module cbc_gram (
  input  logic           clk,
  input  logic           rst,
  input  cbc_pkg::dots_t dots,
  output cbc_pkg::gram_t gram
);
  import cbc_pkg::*;

  localparam int NUM_PROD = 6;

  logic [DOT_W-1:0]         opa [NUM_PROD];
  logic [DOT_W-1:0]         opb [NUM_PROD];
  logic signed [PP_W-1:0]   pp_hh [NUM_PROD];
  logic signed [PP_W-1:0]   pp_hl [NUM_PROD];
  logic signed [PP_W-1:0]   pp_lh [NUM_PROD];
  logic [2*SPLIT_LO-1:0]    pp_ll [NUM_PROD];
  logic [PROD_W-1:0]        prod  [NUM_PROD];
  logic [NUM_W-1:0]         gdet, num_v, num_w;
  logic [3:0]               vld;
  edges_t                   edg [4];
  logic                     degen, neg_v, neg_w;
  logic [MAG_W-1:0]         mag_v, mag_w, gden;

  // Products: d00*d11, d01*d01, d11*d20, d01*d21, d00*d21, d01*d20.
  always_comb begin
    opa[0] = dots.d00; opb[0] = dots.d11;
    opa[1] = dots.d01; opb[1] = dots.d01;
    opa[2] = dots.d11; opb[2] = dots.d20;
    opa[3] = dots.d01; opb[3] = dots.d21;
    opa[4] = dots.d00; opb[4] = dots.d21;
    opa[5] = dots.d01; opb[5] = dots.d20;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[2:0], dots.valid};
    end
  end

  // Partial products on halves, then the recombined wide products.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_PROD; k++) begin
      pp_hh[k] <= $signed(opa[k][DOT_W-1:SPLIT_LO]) * $signed(opb[k][DOT_W-1:SPLIT_LO]);
      pp_hl[k] <= $signed(opa[k][DOT_W-1:SPLIT_LO]) * $signed({1'b0, opb[k][SPLIT_LO-1:0]});
      pp_lh[k] <= $signed({1'b0, opa[k][SPLIT_LO-1:0]}) * $signed(opb[k][DOT_W-1:SPLIT_LO]);
      pp_ll[k] <= opa[k][SPLIT_LO-1:0] * opb[k][SPLIT_LO-1:0];
      prod[k]  <= (PROD_W'(pp_hh[k]) << (2 * SPLIT_LO))
                + (PROD_W'(pp_hl[k] + pp_lh[k]) << SPLIT_LO)
                + PROD_W'(pp_ll[k]);
    end
  end

  // Determinant and numerators, then sign and magnitude.
  always_ff @(posedge clk) begin
    gdet  <= NUM_W'($signed(prod[0])) - NUM_W'($signed(prod[1]));
    num_v <= NUM_W'($signed(prod[2])) - NUM_W'($signed(prod[3]));
    num_w <= NUM_W'($signed(prod[4])) - NUM_W'($signed(prod[5]));
    degen <= gdet[NUM_W-1] || (gdet == '0);
    neg_v <= num_v[NUM_W-1];
    neg_w <= num_w[NUM_W-1];
    mag_v <= num_v[NUM_W-1] ? MAG_W'(-num_v) : MAG_W'(num_v);
    mag_w <= num_w[NUM_W-1] ? MAG_W'(-num_w) : MAG_W'(num_w);
    gden  <= gdet[MAG_W-1:0];
    edg[0] <= dots.edges;
    for (int s = 1; s < 4; s++) begin
      edg[s] <= edg[s-1];
    end
  end

  always_comb begin
    gram.valid = vld[3];
    gram.degen = degen;
    gram.neg_v = neg_v;
    gram.neg_w = neg_w;
    gram.mag_v = mag_v;
    gram.mag_w = mag_w;
    gram.gram  = gden;
    gram.edges = edg[3];
  end

endmodule

// ===== hdl/cbc_div_pipe.sv =====
// ----------------------------------------------------------------------------
// cbc_div_pipe
// Restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module cbc_div_pipe #(
  parameter int DEN_W = 51,
  parameter int QW    = 33
) (
  input  logic             clk,
  input  logic [DEN_W-1:0] rem_in,
  input  logic [QW-1:0]    low_in,
  input  logic [DEN_W-1:0] den_in,
  output logic [QW-1:0]    quo
);

  logic [DEN_W-1:0] rem_q [QW];
  logic [DEN_W-1:0] den_q [QW];
  logic [QW-1:0]    low_q [QW];
  logic [QW-1:0]    quo_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DEN_W-1:0] rem_p, den_p;
    logic [QW-1:0]    low_p, quo_p;
    logic [DEN_W:0]   shifted, trial;

    if (k == 0) begin : g_first
      assign rem_p = rem_in;
      assign den_p = den_in;
      assign low_p = low_in;
      assign quo_p = '0;
    end else begin : g_rest
      assign rem_p = rem_q[k-1];
      assign den_p = den_q[k-1];
      assign low_p = low_q[k-1];
      assign quo_p = quo_q[k-1];
    end

    // Bring down the next dividend bit and try the subtraction.
    assign shifted = {rem_p, low_p[QW-1]};
    assign trial   = shifted - {1'b0, den_p};

    always_ff @(posedge clk) begin
      if (shifted >= {1'b0, den_p}) begin
        rem_q[k] <= trial[DEN_W-1:0];
        quo_q[k] <= {quo_p[QW-2:0], 1'b1};
      end else begin
        rem_q[k] <= shifted[DEN_W-1:0];
        quo_q[k] <= {quo_p[QW-2:0], 1'b0};
      end
      low_q[k] <= {low_p[QW-2:0], 1'b0};
      den_q[k] <= den_p;
    end
  end

  assign quo = quo_q[QW-1];

endmodule

// ===== hdl/cbc_weights.sv =====
// ----------------------------------------------------------------------------
// cbc_weights
// Rounding, saturation, u from v and w, and the edge clamp (3 stages).
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cbc_weights (
  input  logic                                           clk,
  input  logic                                           rst,
  input  logic                                           clamp_enable,
  input  logic                                           in_valid,
  input  cbc_pkg::side_t                                 side,
  input  logic [cbc_pkg::QUO_W-1:0]                      quo_v,
  input  logic [cbc_pkg::QUO_W-1:0]                      quo_w,
  input  logic [cbc_pkg::NUM_EDGES-1:0][cbc_pkg::QUO_W-1:0] quo_t,
  output logic                                           done,
  output logic signed [cbc_pkg::WGT_W-1:0]               weight_u,
  output logic signed [cbc_pkg::WGT_W-1:0]               weight_v,
  output logic signed [cbc_pkg::WGT_W-1:0]               weight_w,
  output logic                                           degenerate
);
  import cbc_pkg::*;

  localparam int SUM_W = WGT_W + 2;

  // Round a quotient half up and saturate it to a signed weight.
  function automatic logic [WGT_W-1:0] round_sat(input logic [QUO_W-1:0] q,
                                                  input logic ovf, input logic neg);
    logic [QUO_W:0]   r;
    logic [WGT_W-1:0] res;
    r = ovf ? {1'b1, {QUO_W{1'b0}}} : (({1'b0, q} + (QUO_W+1)'(1)) >> 1);
    if (!neg) begin
      res = (|r[QUO_W:WGT_W-1]) ? WGT_MAX : r[WGT_W-1:0];
    end else begin
      res = (|r[QUO_W:WGT_W-1]) ? WGT_MIN : -r[WGT_W-1:0];
    end
    return res;
  endfunction

  logic [1:0]               vld;
  side_t                    side1, side2;
  logic [WGT_W-1:0]         v1, w1, u2, v2, w2;
  logic [NUM_EDGES-1:0][T_W-1:0] t1, t2;
  logic [SUM_W-1:0]         usum;
  logic [WGT_W-1:0]         u_next, v_next, w_next;
  logic                     dg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[0], in_valid};
      done <= vld[1];
    end
  end

  // Stage one: rounded weights and saturated edge parameters.
  always_ff @(posedge clk) begin
    v1    <= round_sat(quo_v, side.ovf_v, side.neg_v);
    w1    <= round_sat(quo_w, side.ovf_w, side.neg_w);
    side1 <= side;
    for (int e = 0; e < NUM_EDGES; e++) begin
      if (side.e_low[e]) begin
        t1[e] <= '0;
      end else if (side.e_high[e]) begin
        t1[e] <= T_W'(ONE_Q16);
      end else begin
        t1[e] <= T_W'((quo_t[e] + QUO_W'(1)) >> 1);
      end
    end
  end

  // Stage two: u = 1 - v - w, saturated.
  assign usum = SUM_W'(ONE_Q16) - SUM_W'($signed(v1)) - SUM_W'($signed(w1));

  always_ff @(posedge clk) begin
    if (usum[SUM_W-1:WGT_W-1] != '0 && usum[SUM_W-1:WGT_W-1] != '1) begin
      u2 <= usum[SUM_W-1] ? WGT_MIN : WGT_MAX;
    end else begin
      u2 <= usum[WGT_W-1:0];
    end
    v2    <= v1;
    w2    <= w1;
    t2    <= t1;
    side2 <= side1;
  end

  // Stage three: project onto the edge opposite the first negative weight.
  always_comb begin
    u_next  = u2;
    v_next  = v2;
    w_next  = w2;
    dg_next = side2.degen;
    if (!dg_next && clamp_enable) begin
      if (u2[WGT_W-1]) begin
        dg_next = side2.e_zero[EDGE_BC];
        u_next  = '0;
        v_next  = ONE_Q16 - WGT_W'(t2[EDGE_BC]);
        w_next  = WGT_W'(t2[EDGE_BC]);
      end else if (v2[WGT_W-1]) begin
        dg_next = side2.e_zero[EDGE_CA];
        u_next  = WGT_W'(t2[EDGE_CA]);
        v_next  = '0;
        w_next  = ONE_Q16 - WGT_W'(t2[EDGE_CA]);
      end else if (w2[WGT_W-1]) begin
        dg_next = side2.e_zero[EDGE_AB];
        u_next  = ONE_Q16 - WGT_W'(t2[EDGE_AB]);
        v_next  = WGT_W'(t2[EDGE_AB]);
        w_next  = '0;
      end
    end
    if (dg_next) begin
      u_next = '0;
      v_next = '0;
      w_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    weight_u   <= u_next;
    weight_v   <= v_next;
    weight_w   <= w_next;
    degenerate <= dg_next;
  end

  `CBC_ASSERT_IMPL(a_degen_zero, clk, rst, done && degenerate,
    weight_u == '0 && weight_v == '0 && weight_w == '0, "degenerate item with nonzero weights")
  `CBC_ASSERT_IMPL(a_clamp_nonneg, clk, rst, done && !degenerate && $past(clamp_enable),
    !weight_u[WGT_W-1] && !weight_v[WGT_W-1] && !weight_w[WGT_W-1], "clamped weight negative")

endmodule

// ===== hdl/clamped_barycentric_coords.sv =====
// ----------------------------------------------------------------------------
// clamped_barycentric_coords
// Clamped barycentric weights of a point against a 3D triangle.
// ----------------------------------------------------------------------------
// Result: done is registered together with the weights that it marks.
// Throughput: one item per cycle; busy stays low, an item may enter every cycle.
// The 33-stage quotient dividers (one bit per stage) set most of the latency.
// Reset clears all valid bits and clamp_enable; results are never held back.
`include "assert_macros.svh"

module clamped_barycentric_coords (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_write,
  input  logic                              cfg_data,
  input  logic signed [cbc_pkg::COORD_W-1:0] point_x,
  input  logic signed [cbc_pkg::COORD_W-1:0] point_y,
  input  logic signed [cbc_pkg::COORD_W-1:0] point_z,
  input  logic signed [cbc_pkg::COORD_W-1:0] vert_a_x,
  input  logic signed [cbc_pkg::COORD_W-1:0] vert_a_y,
  input  logic signed [cbc_pkg::COORD_W-1:0] vert_a_z,
  input  logic signed [cbc_pkg::COORD_W-1:0] vert_b_x,
  input  logic signed [cbc_pkg::COORD_W-1:0] vert_b_y,
  input  logic signed [cbc_pkg::COORD_W-1:0] vert_b_z,
  input  logic signed [cbc_pkg::COORD_W-1:0] vert_c_x,
  input  logic signed [cbc_pkg::COORD_W-1:0] vert_c_y,
  input  logic signed [cbc_pkg::COORD_W-1:0] vert_c_z,
  output logic                              done,
  output logic signed [cbc_pkg::WGT_W-1:0]  weight_u,
  output logic signed [cbc_pkg::WGT_W-1:0]  weight_v,
  output logic signed [cbc_pkg::WGT_W-1:0]  weight_w,
  output logic                              degenerate
);
  import cbc_pkg::*;

  item_t                          item;
  dots_t                          dots;
  gram_t                          gram;
  side_t                          side_in;
  side_t                          side_q [QUO_W];
  logic [QUO_W-1:0]               vld_q;
  logic                           clamp_enable;
  logic [QUO_W-1:0]               quo_v, quo_w;
  logic [NUM_EDGES-1:0][QUO_W-1:0] quo_t;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Clamp control register.
  always_ff @(posedge clk) begin
    if (rst) begin
      clamp_enable <= 1'b0;
    end else if (cfg_write) begin
      clamp_enable <= cfg_data;
    end
  end

  always_comb begin
    item.px = point_x;  item.py = point_y;  item.pz = point_z;
    item.ax = vert_a_x; item.ay = vert_a_y; item.az = vert_a_z;
    item.bx = vert_b_x; item.by = vert_b_y; item.bz = vert_b_z;
    item.cx = vert_c_x; item.cy = vert_c_y; item.cz = vert_c_z;
  end

  cbc_dots u_dots (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .item     (item),
    .dots     (dots)
  );

  cbc_gram u_gram (
    .clk  (clk),
    .rst  (rst),
    .dots (dots),
    .gram (gram)
  );

  // Overflow and edge range flags that ride alongside the dividers.
  always_comb begin
    side_in.degen = gram.degen;
    side_in.neg_v = gram.neg_v;
    side_in.neg_w = gram.neg_w;
    side_in.ovf_v = {PRE_SHIFT'(0), gram.mag_v} >= {gram.gram, PRE_SHIFT'(0)};
    side_in.ovf_w = {PRE_SHIFT'(0), gram.mag_w} >= {gram.gram, PRE_SHIFT'(0)};
    for (int e = 0; e < NUM_EDGES; e++) begin
      side_in.e_zero[e] = (gram.edges.ed[e] == '0);
      side_in.e_low[e]  = ($signed(gram.edges.en[e]) <= 0);
      side_in.e_high[e] = ($signed(gram.edges.en[e]) >= $signed(gram.edges.ed[e]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QUO_W-2:0], gram.valid};
    end
  end

  always_ff @(posedge clk) begin
    side_q[0] <= side_in;
    for (int s = 1; s < QUO_W; s++) begin
      side_q[s] <= side_q[s-1];
    end
  end

  // Weight dividers: numerator magnitude over the Gram determinant.
  cbc_div_pipe #(.DEN_W(MAG_W), .QW(QUO_W)) u_div_v (
    .clk    (clk),
    .rem_in ({PRE_SHIFT'(0), gram.mag_v[MAG_W-1:PRE_SHIFT]}),
    .low_in ({gram.mag_v[PRE_SHIFT-1:0], FRAC_PAD'(0)}),
    .den_in (gram.gram),
    .quo    (quo_v)
  );

  cbc_div_pipe #(.DEN_W(MAG_W), .QW(QUO_W)) u_div_w (
    .clk    (clk),
    .rem_in ({PRE_SHIFT'(0), gram.mag_w[MAG_W-1:PRE_SHIFT]}),
    .low_in ({gram.mag_w[PRE_SHIFT-1:0], FRAC_PAD'(0)}),
    .den_in (gram.gram),
    .quo    (quo_w)
  );

  // Edge parameter dividers, one per edge.
  for (genvar e = 0; e < NUM_EDGES; e++) begin : g_edge
    cbc_div_pipe #(.DEN_W(DOT_W), .QW(QUO_W)) u_div_t (
      .clk    (clk),
      .rem_in ({PRE_SHIFT'(0), gram.edges.en[e][DOT_W-1:PRE_SHIFT]}),
      .low_in ({gram.edges.en[e][PRE_SHIFT-1:0], FRAC_PAD'(0)}),
      .den_in (gram.edges.ed[e]),
      .quo    (quo_t[e])
    );
  end

  cbc_weights u_weights (
    .clk          (clk),
    .rst          (rst),
    .clamp_enable (clamp_enable),
    .in_valid     (vld_q[QUO_W-1]),
    .side         (side_q[QUO_W-1]),
    .quo_v        (quo_v),
    .quo_w        (quo_w),
    .quo_t        (quo_t),
    .done         (done),
    .weight_u     (weight_u),
    .weight_v     (weight_v),
    .weight_w     (weight_w),
    .degenerate   (degenerate)
  );

  `CBC_ASSERT_IMPL(a_done_has_item, clk, rst, done,
    $past(start && !busy, PIPE_LATENCY), "result strobe without an accepted item")
  `CBC_ASSERT_NEXT(a_div_entry_valid, clk, rst, gram.valid && !gram.degen,
    vld_q[0] && !side_q[0].degen, "divider entry lost its item")

endmodule

// ===== bench/clamped_barycentric_coords_test.sv =====
// ----------------------------------------------------------------------------
// Clamped barycentric weights testbench
// Drives triangle queries through the block with random bursts and gaps,
// predicts the weights with exact wide arithmetic and checks every result.
// ----------------------------------------------------------------------------
module clamped_barycentric_coords_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cbc_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic signed [127:0] Q16_ONE = 128'sd65536;

  typedef struct {
    logic signed [31:0] u, v, w;
    logic               degen;
  } weights_t;

  logic clk, rst, start, busy, cfg_write, cfg_data;
  logic done, degenerate;
  logic signed [COORD_W-1:0] point_x, point_y, point_z;
  logic signed [COORD_W-1:0] vert_a_x, vert_a_y, vert_a_z;
  logic signed [COORD_W-1:0] vert_b_x, vert_b_y, vert_b_z;
  logic signed [COORD_W-1:0] vert_c_x, vert_c_y, vert_c_z;
  logic signed [WGT_W-1:0] weight_u, weight_v, weight_w;

  item_t    pending_items[$];
  weights_t expected_weights[$];
  item_t    driven_item;
  logic     clamp_on;
  int       burst_left, gap_left, idle_cycles, error_count;

  clamped_barycentric_coords u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cfg_write(cfg_write), .cfg_data(cfg_data),
    .point_x(point_x), .point_y(point_y), .point_z(point_z),
    .vert_a_x(vert_a_x), .vert_a_y(vert_a_y), .vert_a_z(vert_a_z),
    .vert_b_x(vert_b_x), .vert_b_y(vert_b_y), .vert_b_z(vert_b_z),
    .vert_c_x(vert_c_x), .vert_c_y(vert_c_y), .vert_c_z(vert_c_z),
    .done(done), .weight_u(weight_u), .weight_v(weight_v),
    .weight_w(weight_w), .degenerate(degenerate)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Rounded, saturated Q15.16 quotient of num/den with den > 0.
  function automatic logic signed [127:0] q16_quotient(logic signed [127:0] num,
                                                       logic signed [127:0] den);
    logic         neg;
    logic [159:0] mag, quo, r;
    neg = num < 0;
    mag = neg ? 160'(-num) : 160'(num);
    quo = (mag << 17) / 160'(den);
    r = (quo >= (160'd1 << 33)) ? (160'd1 << 33) : ((quo + 1) >> 1);
    if (!neg) return (r > 160'h7FFF_FFFF) ? 128'sh7FFF_FFFF : 128'(r);
    if (r >= 160'h8000_0000) return -128'sh8000_0000;
    return -128'(r);
  endfunction

  function automatic logic signed [127:0] sat_weight(logic signed [127:0] x);
    if (x > 128'sh7FFF_FFFF) return 128'sh7FFF_FFFF;
    if (x < -128'sh8000_0000) return -128'sh8000_0000;
    return x;
  endfunction

  function automatic logic signed [127:0] dot_of(logic signed [127:0] x[3],
                                                 logic signed [127:0] y[3]);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  // Saturated parameter of pt projected on edge s to e; -1 for a zero-length edge.
  function automatic logic signed [127:0] edge_param(logic signed [127:0] pt[3],
                                                     logic signed [127:0] s[3],
                                                     logic signed [127:0] e[3]);
    logic signed [127:0] dp[3], de[3], n, d;
    for (int k = 0; k < 3; k++) begin
      dp[k] = pt[k] - s[k];
      de[k] = e[k] - s[k];
    end
    n = dot_of(dp, de);
    d = dot_of(de, de);
    if (d == 0) return -1;
    if (n <= 0) return 0;
    if (n >= d) return Q16_ONE;
    return q16_quotient(n, d);
  endfunction

  function automatic weights_t predict_weights(item_t it, logic clamp);
    logic signed [127:0] p[3], a[3], b[3], c[3], e0[3], e1[3], e2[3];
    logic signed [127:0] d00, d01, d11, d20, d21, gram, u, v, w, t;
    weights_t res;
    logic degen;
    p = '{it.px, it.py, it.pz};
    a = '{it.ax, it.ay, it.az};
    b = '{it.bx, it.by, it.bz};
    c = '{it.cx, it.cy, it.cz};
    for (int k = 0; k < 3; k++) begin
      e0[k] = b[k] - a[k];
      e1[k] = c[k] - a[k];
      e2[k] = p[k] - a[k];
    end
    d00 = dot_of(e0, e0);
    d01 = dot_of(e0, e1);
    d11 = dot_of(e1, e1);
    d20 = dot_of(e2, e0);
    d21 = dot_of(e2, e1);
    gram = d00 * d11 - d01 * d01;
    u = 0; v = 0; w = 0; degen = 1'b0;
    if (gram <= 0) begin
      degen = 1'b1;
    end else begin
      v = q16_quotient(d11 * d20 - d01 * d21, gram);
      w = q16_quotient(d00 * d21 - d01 * d20, gram);
      u = sat_weight(Q16_ONE - v - w);
      // The first negative weight picks the edge opposite its vertex.
      if (clamp) begin
        if (u < 0) begin
          t = edge_param(p, b, c);
          if (t < 0) degen = 1'b1;
          else begin u = 0; v = Q16_ONE - t; w = t; end
        end else if (v < 0) begin
          t = edge_param(p, c, a);
          if (t < 0) degen = 1'b1;
          else begin u = t; v = 0; w = Q16_ONE - t; end
        end else if (w < 0) begin
          t = edge_param(p, a, b);
          if (t < 0) degen = 1'b1;
          else begin u = Q16_ONE - t; v = t; w = 0; end
        end
      end
      if (degen) begin u = 0; v = 0; w = 0; end
    end
    res.u = u[31:0];
    res.v = v[31:0];
    res.w = w[31:0];
    res.degen = degen;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Sender: bursts of items from the pending queue, separated by random gaps.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (start && !busy) expected_weights.push_back(predict_weights(driven_item, clamp_on));
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          start <= 1'b0;
        end else if (pending_items.size() > 0) begin
          driven_item = pending_items.pop_front();
          {point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y,
           vert_b_z, vert_c_x, vert_c_y, vert_c_z} <= driven_item;
          start <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 30);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result checker: every strobe is matched against the oldest prediction.
  always @(posedge clk) begin
    weights_t want;
    if (!rst && done) begin
      if (expected_weights.size() == 0) begin
        report_mismatch("unexpected result", {31'b0, degenerate}, 32'b0);
      end else begin
        want = expected_weights.pop_front();
        if (weight_u !== want.u) report_mismatch("weight_u", weight_u, want.u);
        if (weight_v !== want.v) report_mismatch("weight_v", weight_v, want.v);
        if (weight_w !== want.w) report_mismatch("weight_w", weight_w, want.w);
        if (degenerate !== want.degen)
          report_mismatch("degenerate", {31'b0, degenerate}, {31'b0, want.degen});
      end
    end
  end

  // Watchdog on cycles where work is outstanding but nothing moves.
  always @(posedge clk) begin
    if (rst || (start && !busy) || done ||
        (pending_items.size() == 0 && expected_weights.size() == 0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic item_t make_item(int px, int py, int pz, int ax, int ay, int az,
                                      int bx, int by, int bz, int cx, int cy, int cz);
    item_t it;
    it = '{coord_t'(px), coord_t'(py), coord_t'(pz), coord_t'(ax), coord_t'(ay),
           coord_t'(az), coord_t'(bx), coord_t'(by), coord_t'(bz), coord_t'(cx),
           coord_t'(cy), coord_t'(cz)};
    return it;
  endfunction

  function automatic int near_coord(int base, int spread);
    return base + $urandom_range(0, 2 * spread) - spread;
  endfunction

  // Random query: mostly small triangles with the point around them.
  function automatic item_t random_item();
    item_t it;
    int kind, spread, bx, by, bz, ox, oy, oz;
    kind = $urandom_range(0, 9);
    if (kind <= 1) begin
      it = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom};
      return it;
    end
    spread = (kind <= 5) ? $urandom_range(16, 8192) : $urandom_range(1, 1 << 20);
    bx = near_coord(0, 4000000);
    by = near_coord(0, 4000000);
    bz = near_coord(0, 4000000);
    it.ax = coord_t'(near_coord(bx, spread));
    it.ay = coord_t'(near_coord(by, spread));
    it.az = coord_t'(near_coord(bz, spread));
    it.bx = coord_t'(near_coord(bx, spread));
    it.by = coord_t'(near_coord(by, spread));
    it.bz = coord_t'(near_coord(bz, spread));
    it.cx = coord_t'(near_coord(bx, spread));
    it.cy = coord_t'(near_coord(by, spread));
    it.cz = coord_t'(near_coord(bz, spread));
    it.px = coord_t'(near_coord(bx, 2 * spread));
    it.py = coord_t'(near_coord(by, 2 * spread));
    it.pz = coord_t'(near_coord(bz, 2 * spread));
    if (kind == 9) begin
      // Collinear or coincident vertices.
      ox = it.bx - it.ax; oy = it.by - it.ay; oz = it.bz - it.az;
      if ($urandom_range(0, 1)) begin ox = 0; oy = 0; oz = 0; end
      it.bx = coord_t'(it.ax + ox);
      it.by = coord_t'(it.ay + oy);
      it.bz = coord_t'(it.az + oz);
      it.cx = coord_t'(it.ax + 2 * ox);
      it.cy = coord_t'(it.ay + 2 * oy);
      it.cz = coord_t'(it.az + 2 * oz);
    end
    return it;
  endfunction

  task automatic load_directed();
    int mx, mn;
    mx = 8388607;
    mn = -8388608;
    pending_items.push_back(make_item(mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx));
    pending_items.push_back(make_item(mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn));
    pending_items.push_back(make_item(mx, mx, mx, mn, mn, mn, mx, mn, mn, mn, mx, mn));
    pending_items.push_back(make_item(mn, mn, mn, mx, mx, 0, mn, mx, 0, mx, mn, mx));
    pending_items.push_back(make_item(mx, mn, mx, 0, 0, 0, 1, 0, 0, 0, 1, 0));
    pending_items.push_back(make_item(mn, mx, mn, 0, 0, 0, 0, 1, 0, 0, 0, 1));
    // Point inside, on a vertex, and beyond each edge of a right triangle.
    pending_items.push_back(make_item(1000, 1000, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
    pending_items.push_back(make_item(4096, 0, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
    pending_items.push_back(make_item(6000, 6000, 100, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
    pending_items.push_back(make_item(-3000, 1000, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
    pending_items.push_back(make_item(1000, -3000, -50, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
    pending_items.push_back(make_item(-9000, 9000, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
    pending_items.push_back(make_item(9000, -9000, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
    pending_items.push_back(make_item(-5000, -5000, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
    pending_items.push_back(make_item(2048, 2048, 0, 0, 0, 0, 4096, 0, 0, 0, 4096, 0));
    // Degenerate triangles: coincident and collinear vertices.
    pending_items.push_back(make_item(5, 6, 7, 100, 100, 100, 100, 100, 100, 100, 100, 100));
    pending_items.push_back(make_item(5, 6, 7, 0, 0, 0, 10, 20, 30, 20, 40, 60));
    pending_items.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    // Huge point against a tiny triangle saturates the weights.
    pending_items.push_back(make_item(mx, mx, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
    pending_items.push_back(make_item(mn, mx, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
  endtask

  task automatic set_clamp(logic value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    clamp_on = value;
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && !start && expected_weights.size() == 0);
    repeat (PIPE_LATENCY + 5) @(posedge clk);
  endtask

  // Phases alternate the clamp setting; the block is drained between them.
  initial begin
    rst = 1'b1;
    start = 1'b0;
    cfg_write = 1'b0;
    cfg_data = 1'b0;
    clamp_on = 1'b0;
    driven_item = '0;
    {point_x, point_y, point_z, vert_a_x, vert_a_y, vert_a_z} = '0;
    {vert_b_x, vert_b_y, vert_b_z, vert_c_x, vert_c_y, vert_c_z} = '0;
    error_count = 0;
    idle_cycles = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 6; phase++) begin
      set_clamp(1'(phase % 2));
      if (phase < 2) load_directed();
      for (int i = 0; i < 225; i++) pending_items.push_back(random_item());
      drain();
    end
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
